@@ src/d2i_pkg.sv @@
// Package with shared types, constants and codes of the double to int32 converter.
package d2i_pkg;

    localparam int unsigned DataWidth = 64;
    localparam int unsigned FracBits  = 52;
    localparam int unsigned ExpBits   = 11;
    localparam logic [10:0] ExpMax    = 11'h7FF;
    localparam logic [10:0] Bias      = 11'd1023;

    typedef enum logic [1:0] {
        OP_TO_INT32  = 2'd0,
        OP_TO_UINT16 = 2'd1,
        OP_TRUNC     = 2'd2,
        OP_TO_BOOL   = 2'd3
    } op_t;

endpackage

@@ src/d2i_in_if.sv @@
// Channel interfaces for operand and result transactions.
interface d2i_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [63:0] operand_bits;

    modport source (output valid, output op, output operand_bits, input ready);
    modport sink   (input valid, input op, input operand_bits, output ready);
endinterface

interface d2i_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_bits;

    modport source (output valid, output result_bits, input ready);
    modport sink   (input valid, input result_bits, output ready);
endinterface

@@ src/d2i_convert.sv @@
// Combinational conversion of one binary64 operand according to the op code.
module d2i_convert (
    input  logic [1:0]  op,
    input  logic [63:0] operand_bits,
    output logic [63:0] result_bits
);

    logic [10:0] expo;
    logic [52:0] sig;
    logic        is_max;
    logic        frac_nz;
    logic [31:0] mag;
    logic [31:0] int_res;
    logic [63:0] trunc_res;
    logic [5:0]  rsh;
    logic [5:0]  lsh;
    logic [63:0] keep_mask;
    logic [11:0] diff;

    always_comb
    begin
        expo    = operand_bits[62:52];
        sig     = {1'b1, operand_bits[51:0]};
        is_max  = (expo == d2i_pkg::ExpMax);
        frac_nz = (operand_bits[51:0] != 52'd0);
        // Signed distance of the exponent from the point where the significand is integral.
        diff    = {1'b0, expo} - 12'd1075;
        rsh     = 6'(12'd0 - diff);
        lsh     = diff[5:0];
        mag     = 32'd0;
        if (!is_max && expo >= d2i_pkg::Bias)
        begin
            if (!diff[11])
            begin
                if (diff < 12'd32)
                    mag = 32'({11'd0, sig} << lsh);
            end
            else
            begin
                mag = 32'(sig >> rsh);
            end
        end
        int_res = operand_bits[63] ? (32'd0 - mag) : mag;

        keep_mask = ~((64'd1 << rsh) - 64'd1);
        if (is_max)
            trunc_res = frac_nz ? 64'd0 : operand_bits;
        else if (expo < d2i_pkg::Bias)
            trunc_res = {operand_bits[63], 63'd0};
        else if (!diff[11])
            trunc_res = operand_bits;
        else
            trunc_res = operand_bits & keep_mask;

        case (d2i_pkg::op_t'(op))
            d2i_pkg::OP_TO_INT32:  result_bits = {32'd0, int_res};
            d2i_pkg::OP_TO_UINT16: result_bits = {48'd0, int_res[15:0]};
            d2i_pkg::OP_TRUNC:     result_bits = trunc_res;
            d2i_pkg::OP_TO_BOOL:
                result_bits = {63'd0, !(is_max && frac_nz) && (operand_bits[62:0] != 63'd0)};
            default:               result_bits = 64'd0;
        endcase
    end

endmodule

@@ src/double_to_int32_converter_top.sv @@
// Top level of the double to int32 converter: input register, conversion, result register.
//
// Usage: an operand transaction (op, operand_bits) enters on the in channel and one
// result transaction (result_bits) leaves on the out channel for each operand.
// From acceptance to a valid result, the operand is captured in an input register,
// converted by one pass of exponent decode and significand shift, and captured
// in the result register. Throughput is one transaction per cycle; the two register
// stages form a pipeline that advances whenever the result register is empty or
// being taken.
// When the receiver stalls, the result register holds its value and the input
// register fills; ready then drops until the receiver takes the result.
// Reset clears both valid flags; nothing is in flight after reset, and ready is
// high in the first cycle after reset.
module double_to_int32_converter_top (
    input  logic      clk,
    input  logic      rst_n,
    d2i_in_if.sink    in_ch,
    d2i_out_if.source out_ch
);

    logic        s1_valid_reg;
    logic [1:0]  s1_op_reg;
    logic [63:0] s1_bits_reg;
    logic        out_valid_reg;
    logic [63:0] out_bits_reg;
    logic [63:0] conv_bits;
    logic        out_adv;
    logic        s1_adv;

    assign out_adv     = !out_valid_reg || out_ch.ready;
    assign s1_adv      = !s1_valid_reg || out_adv;
    assign in_ch.ready = s1_adv;

    d2i_convert u_conv (
        .op          (s1_op_reg),
        .operand_bits(s1_bits_reg),
        .result_bits (conv_bits)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
                s1_valid_reg <= in_ch.valid;
            if (out_adv)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && in_ch.valid)
        begin
            s1_op_reg   <= in_ch.op;
            s1_bits_reg <= in_ch.operand_bits;
        end
        if (out_adv && s1_valid_reg)
            out_bits_reg <= conv_bits;
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.result_bits = out_bits_reg;

    // A stalled result must hold.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ch.ready |=> out_valid_reg && $stable(out_bits_reg))
        else $error("result changed under stall");
    // An accepted operand is held in the input register in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready && out_adv |=> s1_valid_reg)
        else $error("accepted operand lost");
    // Ready only drops when both stages are full.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> s1_valid_reg && out_valid_reg)
        else $error("ready dropped with free space");

endmodule
